@@ rtl/core/sabs_pkg.sv @@
// Shared types and constants of the sorted array binary search block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sabs_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int DATA_W      = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [ADDR_W-1:0]        write_index;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_index;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/sorted_array_binary_search.sv @@
// Top level of the sorted array binary search block: stream ports, count
// register and output register. Depends on sabs_pkg and sabs_engine.
//
// The block holds up to 1024 signed 32-bit elements in a single-port
// synchronous memory that software fills in ascending order by write
// transactions (tuser 0), which produce no result. A search
// transaction (tuser 1) carries a key and produces one result transaction:
// a found flag and the index of the first midpoint that matched, or index
// zero when the key is absent. The search range is indices 0 to
// element_count-1, where element_count is set through the configuration port
// and saturates at 1024. The search probes one midpoint per cycle, and a full
// store needs up to eleven probes. The element memory has a registered read
// port. The block handles one transaction at a time; the result sits in an
// output register, so the next transaction is accepted while that result
// still waits to be taken.
// The memory has no reset: searching over entries never written gives an
// undefined result.
`default_nettype none

module sorted_array_binary_search
    import sabs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata,   // element_count
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [47:0]        s_axis_tdata,  // write_index[9:0], value[41:10], zero
    input  wire logic [0:0]         s_axis_tuser,  // op
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [15:0]             m_axis_tdata,  // match_index[9:0], zero
    output logic [0:0]              m_axis_tuser   // found
);

    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_result            r_out;

    t_req    req;
    t_result eng_res;
    logic    eng_ready;
    logic    eng_res_valid;
    logic    res_take;

    // Counts above the store depth are clamped as they are written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata > COUNT_W'(STORE_DEPTH)) begin
                r_count <= COUNT_W'(STORE_DEPTH);
            end else begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    assign req.op          = s_axis_tuser[0];
    assign req.write_index = s_axis_tdata[ADDR_W-1:0];
    assign req.value       = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];

    sabs_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid),
        .i_req       (req),
        .o_ready     (eng_ready),
        .i_count     (r_count),
        .o_res_valid (eng_res_valid),
        .i_res_ready (res_take),
        .o_res       (eng_res)
    );

    assign s_axis_tready = eng_ready;

    // The output register takes a new result when it is empty or is being
    // emptied in the same cycle.
    assign res_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= eng_res_valid;
        end
        if (res_take && eng_res_valid) begin
            r_out <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(16 - ADDR_W)'(0), r_out.match_index};
    assign m_axis_tuser  = r_out.found;

endmodule

`default_nettype wire

@@ rtl/core/sabs_engine.sv @@
// Element store and probe sequencer of the sorted array binary search block.
// Depends on sabs_pkg for widths, operation codes and the request and result types.
`default_nettype none

module sabs_engine
    import sabs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_req               i_req,
    output logic                    o_ready,
    input  wire logic [COUNT_W-1:0] i_count,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output t_result                 o_res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [COUNT_W-1:0]       r_lo, n_lo;
    logic [COUNT_W-1:0]       r_hi_ex, n_hi_ex;
    logic [ADDR_W-1:0]        r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_found, n_found;
    logic [ADDR_W-1:0]        r_match, n_match;

    logic signed [DATA_W-1:0] store_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;

    logic [COUNT_W-1:0] mid_ext;
    logic [COUNT_W-1:0] first_mid;
    logic [COUNT_W-1:0] left_diff, left_mid;
    logic [COUNT_W-1:0] right_lo, right_diff, right_mid;
    logic               left_ok, right_ok;

    // Both possible next midpoints are prepared from registers, so the
    // element compare only has to pick one of them.
    always_comb begin
        mid_ext    = {1'b0, r_mid};
        first_mid  = (i_count - COUNT_W'(1)) >> 1;
        left_ok    = r_lo < mid_ext;
        left_diff  = mid_ext - COUNT_W'(1) - r_lo;
        left_mid   = r_lo + (left_diff >> 1);
        right_lo   = mid_ext + COUNT_W'(1);
        right_ok   = right_lo < r_hi_ex;
        right_diff = r_hi_ex - COUNT_W'(1) - right_lo;
        right_mid  = right_lo + (right_diff >> 1);
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi_ex = r_hi_ex;
        n_mid   = r_mid;
        n_key   = r_key;
        n_found = r_found;
        n_match = r_match;
        rd_en   = 1'b0;
        rd_addr = r_mid;
        wr_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.op == OP_WRITE) begin
                        wr_en = {1'b0, i_req.write_index} < COUNT_W'(STORE_DEPTH);
                    end else begin
                        n_key   = i_req.value;
                        n_lo    = '0;
                        n_hi_ex = i_count;
                        n_found = 1'b0;
                        n_match = '0;
                        if (i_count == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_mid   = first_mid[ADDR_W-1:0];
                            rd_en   = 1'b1;
                            rd_addr = first_mid[ADDR_W-1:0];
                            n_state = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE: begin
                priority if (r_rd_data == r_key) begin
                    n_found = 1'b1;
                    n_match = r_mid;
                    n_state = S_DONE;
                end else if (r_rd_data > r_key) begin
                    n_hi_ex = mid_ext;
                    if (left_ok) begin
                        n_mid   = left_mid[ADDR_W-1:0];
                        rd_en   = 1'b1;
                        rd_addr = left_mid[ADDR_W-1:0];
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_lo = right_lo;
                    if (right_ok) begin
                        n_mid   = right_mid[ADDR_W-1:0];
                        rd_en   = 1'b1;
                        rd_addr = right_mid[ADDR_W-1:0];
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            store_mem[i_req.write_index] <= i_req.value;
        end
        if (rd_en) begin
            r_rd_data <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo    <= n_lo;
        r_hi_ex <= n_hi_ex;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
        r_match <= n_match;
    end

    assign o_ready           = r_state == S_IDLE;
    assign o_res_valid       = r_state == S_DONE;
    assign o_res.found       = r_found;
    assign o_res.match_index = r_match;

    // The probed entry always lies inside the half-open search range.
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> (r_lo <= mid_ext) && (mid_ext < r_hi_ex))
        else $error("probe outside search range");

    // The range never reaches past the store.
    a_range_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> r_hi_ex <= COUNT_W'(STORE_DEPTH))
        else $error("search range beyond store");

    // A miss reports index zero.
    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |-> o_res.match_index == '0)
        else $error("miss with non-zero index");

    // A probe leaves the sequencer either probing again with a fresh read or done.
    a_probe_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |=> (r_state == S_DONE) || (r_state == S_PROBE && $past(rd_en)))
        else $error("probe continued without a read");

    // A write transaction returns to idle at once.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && o_ready && i_req.op == OP_WRITE) |=> r_state == S_IDLE)
        else $error("write transaction left idle");

endmodule

`default_nettype wire
